[hw/rtl/ftfn_pkg.sv]
// Shared constants and register map for the fixed-to-float normalizer.
`timescale 1ns / 1ps

package ftfn_pkg;

	// Default format: Q32.32 input, up to 32 mantissa bits
	localparam int INT_BITS_DEF     = 32;
	localparam int FRAC_BITS_DEF    = 32;
	localparam int MAX_MANTISSA_DEF = 32;

	// Fixed field widths
	localparam int VALUE_W = 64;
	localparam int MANT_W  = 32;
	localparam int EXP_W   = 7;
	localparam int CFG_MW  = 6;
	localparam int CFG_EW  = 8;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_MANT_BITS = 2'd0;
	localparam logic [1:0] REG_MIN_EXP   = 2'd1;
	localparam logic [1:0] REG_MAX_EXP   = 2'd2;

	// Reset values
	localparam logic [CFG_MW-1:0] MANT_BITS_RST = 6'd23;
	localparam logic [CFG_EW-1:0] MIN_EXP_RST   = 8'hE1; // -31
	localparam logic [CFG_EW-1:0] MAX_EXP_RST   = 8'h20; // 32

endpackage

[hw/rtl/fixed_to_float_normalizer_unit.sv]
// Top level: four-stage pipelined fixed-point to float normalizer with APB registers.
`timescale 1ns / 1ps

// Takes one signed fixed-point word per cycle (start high; busy is always low, so
// every start is taken) and returns its result word from the last stage register,
// marked by done for a single cycle. Results cannot be held off, and nothing stalls:
// the four stages are magnitude, leading/trailing-one detect, normalize shift with
// exponent checks, and mantissa select with complements. Write the APB registers
// (mantissa_bits at 0x0, min_exponent at 0x4, max_exponent at 0x8) only while no
// word is in flight. A zero input gives zero_flag with every other field zero,
// except sign, which still shows the input's sign bit.
module fixed_to_float_normalizer_unit
	import ftfn_pkg::*;
#(
	parameter int INT_BITS     = INT_BITS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int MAX_MANTISSA = MAX_MANTISSA_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// command side
	input  logic                     start,
	output logic                     busy,
	input  logic signed [VALUE_W-1:0] value,
	// result side
	output logic                     done,
	output logic                     sign,
	output logic signed [EXP_W-1:0]  exponent,
	output logic [MANT_W-1:0]        mantissa,
	output logic [MANT_W-1:0]        ones_complement,
	output logic [MANT_W-1:0]        twos_complement,
	output logic                     zero_flag,
	output logic                     overflow_flag,
	output logic                     underflow_flag,
	output logic                     truncation_flag,
	// APB configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	localparam int W  = INT_BITS + FRAC_BITS;
	localparam int TW = $clog2(W);

	// configuration registers
	logic [CFG_MW-1:0]        mant_bits_q;
	logic signed [CFG_EW-1:0] min_exp_q;
	logic signed [CFG_EW-1:0] max_exp_q;
	logic                     cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mant_bits_q <= MANT_BITS_RST;
			min_exp_q   <= MIN_EXP_RST;
			max_exp_q   <= MAX_EXP_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MANT_BITS: mant_bits_q <= pwdata[CFG_MW-1:0];
				REG_MIN_EXP:   min_exp_q   <= pwdata[CFG_EW-1:0];
				REG_MAX_EXP:   max_exp_q   <= pwdata[CFG_EW-1:0];
				default:       ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_MANT_BITS: prdata = DATA_W'(mant_bits_q);
			REG_MIN_EXP:   prdata = DATA_W'(unsigned'(min_exp_q));
			REG_MAX_EXP:   prdata = DATA_W'(unsigned'(max_exp_q));
			default:       prdata = '0;
		endcase
	end

	// effective mantissa width, clamped to 1..MAX_MANTISSA
	logic [CFG_MW-1:0] m_eff;
	always_comb begin
		if (mant_bits_q == '0)
			m_eff = CFG_MW'(1);
		else if (mant_bits_q > CFG_MW'(MAX_MANTISSA))
			m_eff = CFG_MW'(MAX_MANTISSA);
		else
			m_eff = mant_bits_q;
	end

	// the pipeline never stalls
	assign busy = 1'b0;

	// ---------------- stage 1: sign and magnitude ----------------
	logic             vld_s1, neg_s1;
	logic [W-1:0]     mag_s1;
	logic [VALUE_W-1:0] mag_full;

	assign mag_full = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		neg_s1 <= value[VALUE_W-1];
		mag_s1 <= mag_full[W-1:0];
	end

	// ---------------- stage 2: leading and trailing one ----------------
	logic          vld_s2, neg_s2, zero_s2;
	logic [W-1:0]  mag_s2;
	logic [TW-1:0] top_s2, low_s2;
	logic [TW-1:0] top_c, low_c;

	always_comb begin
		top_c = '0;
		for (int i = 0; i < W; i++)
			if (mag_s1[i]) top_c = TW'(i);
	end

	always_comb begin
		low_c = '0;
		for (int i = W - 1; i >= 0; i--)
			if (mag_s1[i]) low_c = TW'(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		neg_s2  <= neg_s1;
		zero_s2 <= (mag_s1 == '0);
		mag_s2  <= mag_s1;
		top_s2  <= top_c;
		low_s2  <= low_c;
	end

	// ---------------- stage 3: normalize, exponent and flags ----------------
	logic                     vld_s3, neg_s3, zero_s3;
	logic [MANT_W-1:0]        norm_hi_s3;
	logic signed [CFG_EW-1:0] exp_s3;
	logic                     ovf_s3, unf_s3, trunc_s3;
	logic [VALUE_W-1:0]       norm_c;
	logic [5:0]               shamt_c;
	logic signed [CFG_EW-1:0] exp_c;
	logic [6:0]               span_c;
	logic                     ovf_c, unf_c;

	assign shamt_c = 6'd63 - 6'(top_s2);
	assign norm_c  = VALUE_W'(mag_s2) << shamt_c;
	// e = top - FRAC_BITS + 1
	assign exp_c   = $signed(CFG_EW'(top_s2)) - $signed(CFG_EW'(FRAC_BITS - 1));
	assign span_c  = 7'(top_s2) - 7'(low_s2) + 7'd1;
	assign ovf_c   = exp_c > max_exp_q;
	assign unf_c   = !ovf_c && (exp_c < min_exp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		neg_s3     <= neg_s2;
		zero_s3    <= zero_s2;
		norm_hi_s3 <= norm_c[VALUE_W-1 -: MANT_W];
		exp_s3     <= zero_s2 ? '0 : exp_c;
		ovf_s3     <= !zero_s2 && ovf_c;
		unf_s3     <= !zero_s2 && unf_c;
		trunc_s3   <= !zero_s2 && (span_c > 7'(m_eff));
	end

	// ---------------- stage 4: mantissa select and complements ----------------
	logic              vld_s4, sign_s4, zero_s4, ovf_s4, unf_s4, trunc_s4;
	logic [EXP_W-1:0]  exp_s4;
	logic [MANT_W-1:0] mant_s4, ones_s4, twos_s4;
	logic [5:0]        drop_c;
	logic [MANT_W-1:0] mask_c, mant_c, ones_c, twos_c;

	assign drop_c = 6'd32 - m_eff;
	assign mask_c = {MANT_W{1'b1}} >> drop_c;
	assign mant_c = norm_hi_s3 >> drop_c;
	assign ones_c = ~mant_c & mask_c;
	assign twos_c = (ones_c + MANT_W'(1)) & mask_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		sign_s4  <= neg_s3;
		zero_s4  <= zero_s3;
		ovf_s4   <= ovf_s3;
		unf_s4   <= unf_s3;
		trunc_s4 <= trunc_s3;
		exp_s4   <= exp_s3[EXP_W-1:0];
		mant_s4  <= zero_s3 ? '0 : mant_c;
		ones_s4  <= zero_s3 ? '0 : ones_c;
		twos_s4  <= zero_s3 ? '0 : twos_c;
	end

	// result word
	assign done            = vld_s4;
	assign sign            = sign_s4;
	assign exponent        = $signed(exp_s4);
	assign mantissa        = mant_s4;
	assign ones_complement = ones_s4;
	assign twos_complement = twos_s4;
	assign zero_flag       = zero_s4;
	assign overflow_flag   = ovf_s4;
	assign underflow_flag  = unf_s4;
	assign truncation_flag = trunc_s4;

endmodule

[hw/rtl/ftfn_checker.sv]
// Port-level checker for the normalizer, bound to the top level.
`timescale 1ns / 1ps

module ftfn_checker
	import ftfn_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic signed [EXP_W-1:0]  exponent,
	input logic [MANT_W-1:0]        mantissa,
	input logic [MANT_W-1:0]        ones_complement,
	input logic                     zero_flag,
	input logic                     overflow_flag,
	input logic                     underflow_flag,
	input logic                     truncation_flag
);

	// every word is taken
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// each accepted word comes back as a done result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n) start |-> ##4 done)
		else $error("result missing four cycles after start");

	// no result without a matching accepted word
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result without a matching start");

	// zero result clears mantissa, ones complement, exponent and every flag but zero_flag
	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_flag) |-> (mantissa == '0 && ones_complement == '0 &&
		exponent == '0 && !overflow_flag && !underflow_flag && !truncation_flag))
		else $error("zero result carries nonzero fields");

	// complement never overlaps the mantissa, and overflow beats underflow
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((mantissa & ones_complement) == '0 &&
		!(overflow_flag && underflow_flag)))
		else $error("inconsistent result fields");

endmodule

bind fixed_to_float_normalizer_unit ftfn_checker u_ftfn_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.exponent        (exponent),
	.mantissa        (mantissa),
	.ones_complement (ones_complement),
	.zero_flag       (zero_flag),
	.overflow_flag   (overflow_flag),
	.underflow_flag  (underflow_flag),
	.truncation_flag (truncation_flag)
);

[tb/fixed_to_float_normalizer_unit_tb.sv]
// Self-checking testbench for the fixed-to-float normalizer: directed table plus random words.
`timescale 1ns / 1ps

module fixed_to_float_normalizer_unit_tb;
	import ftfn_pkg::*;

	// one normalized result word
	typedef struct packed {
		logic                    sign;
		logic signed [EXP_W-1:0] exponent;
		logic [MANT_W-1:0]       mantissa;
		logic [MANT_W-1:0]       ones_complement;
		logic [MANT_W-1:0]       twos_complement;
		logic                    zero_flag;
		logic                    overflow_flag;
		logic                    underflow_flag;
		logic                    truncation_flag;
	} norm_word_t;

	// directed row: input word, plus a hand-written result where typed is set
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               typed;
		norm_word_t         want;
	} dir_row_t;

	// register setting for one phase of the run
	typedef struct packed {
		logic [5:0]        mant_bits;
		logic signed [7:0] min_exp;
		logic signed [7:0] max_exp;
	} cfg_set_t;

	localparam int N_DIR = 18;
	localparam int N_FIXED_SETS = 6;
	localparam int N_RANDOM_SETS = 3;
	localparam int WORDS_PER_SET = 80;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [VALUE_W-1:0]  value;
	logic                done;
	logic                sign;
	logic signed [EXP_W-1:0] exponent;
	logic [MANT_W-1:0]   mantissa;
	logic [MANT_W-1:0]   ones_complement;
	logic [MANT_W-1:0]   twos_complement;
	logic                zero_flag;
	logic                overflow_flag;
	logic                underflow_flag;
	logic                truncation_flag;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// shadow copy of the register file
	int mant_bits_cfg;
	int min_exp_cfg;
	int max_exp_cfg;

	norm_word_t pending_words[$];
	int mismatch_count;
	int burst_left;
	bit gaps_on;

	// zero, unit LSB, the extremes, and truncation around the default 23-bit width
	dir_row_t dir_rows[N_DIR] = '{
		'{64'h0000_0000_0000_0000, 1'b1,
			'{1'b0, 7'h00, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0, 1'b0}},
		// smallest magnitude: exponent -31
		'{64'h0000_0000_0000_0001, 1'b1,
			'{1'b0, 7'h61, 32'h0040_0000, 32'h003F_FFFF, 32'h0040_0000,
				1'b0, 1'b0, 1'b0, 1'b0}},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			'{1'b1, 7'h61, 32'h0040_0000, 32'h003F_FFFF, 32'h0040_0000,
				1'b0, 1'b0, 1'b0, 1'b0}},
		// most negative word: magnitude 2^63
		'{64'h8000_0000_0000_0000, 1'b1,
			'{1'b1, 7'h20, 32'h0040_0000, 32'h003F_FFFF, 32'h0040_0000,
				1'b0, 1'b0, 1'b0, 1'b0}},
		'{64'h7FFF_FFFF_FFFF_FFFF, 1'b1,
			'{1'b0, 7'h1F, 32'h007F_FFFF, 32'h0000_0000, 32'h0000_0001,
				1'b0, 1'b0, 1'b0, 1'b1}},
		'{64'h0000_0001_0000_0000, 1'b0, '0},
		'{64'h0000_0000_8000_0000, 1'b0, '0},
		'{64'hFFFF_FFFF_0000_0000, 1'b0, '0},
		'{64'h0000_0000_007F_FFFF, 1'b0, '0},
		'{64'h0000_0000_00FF_FFFF, 1'b0, '0},
		'{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
		'{64'h5555_5555_5555_5555, 1'b0, '0},
		'{64'h4000_0000_0000_0000, 1'b0, '0},
		'{64'h8000_0000_0000_0001, 1'b0, '0},
		'{64'h0000_0000_0000_0003, 1'b0, '0},
		'{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0},
		'{64'h0000_7FFF_FFFF_0000, 1'b0, '0},
		'{64'h1234_5678_9ABC_DEF0, 1'b0, '0}
	};

	// width extremes (0 and above 32 clamp), exponent limits wide open, swapped, equal
	cfg_set_t fixed_sets[N_FIXED_SETS] = '{
		'{6'd32, -8'sd31, 8'sd32},
		'{6'd1, -8'sd64, 8'sd64},
		'{6'd0, -8'sd128, 8'sd127},
		'{6'd63, 8'sd127, -8'sd128},
		'{6'd24, 8'sd0, 8'sd0},
		'{6'd33, 8'sd64, -8'sd64}
	};

	fixed_to_float_normalizer_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.value           (value),
		.done            (done),
		.sign            (sign),
		.exponent        (exponent),
		.mantissa        (mantissa),
		.ones_complement (ones_complement),
		.twos_complement (twos_complement),
		.zero_flag       (zero_flag),
		.overflow_flag   (overflow_flag),
		.underflow_flag  (underflow_flag),
		.truncation_flag (truncation_flag),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the pipeline hangs
	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// normalize one input word under the current register setting
	function automatic norm_word_t normalize_value(logic [VALUE_W-1:0] raw);
		norm_word_t r;
		logic [63:0] mag;
		logic [63:0] norm;
		logic [63:0] mant;
		logic [63:0] mmask;
		logic [63:0] ones;
		logic [63:0] twos;
		int top;
		int low;
		int e;
		int m;
		r = '0;
		r.sign = raw[63];
		mag = raw[63] ? (~raw + 64'd1) : raw;
		if (mag == 64'd0) begin
			r.zero_flag = 1'b1;
			return r;
		end
		m = mant_bits_cfg;
		if (m < 1)
			m = 1;
		if (m > MAX_MANTISSA_DEF)
			m = MAX_MANTISSA_DEF;
		top = 63;
		while (!mag[top])
			top--;
		low = 0;
		while (!mag[low])
			low++;
		e = top - FRAC_BITS_DEF + 1;
		norm = mag << (63 - top);
		mant = norm >> (64 - m);
		mmask = (64'd1 << m) - 64'd1;
		ones = ~mant & mmask;
		twos = (ones + 64'd1) & mmask;
		r.exponent = e[EXP_W-1:0];
		r.mantissa = mant[MANT_W-1:0];
		r.ones_complement = ones[MANT_W-1:0];
		r.twos_complement = twos[MANT_W-1:0];
		// overflow is tested first and wins
		if (e > max_exp_cfg)
			r.overflow_flag = 1'b1;
		else if (e < min_exp_cfg)
			r.underflow_flag = 1'b1;
		r.truncation_flag = (top - low + 1) > m;
		return r;
	endfunction

	// random word: leading one spread over all positions, varied trailing zeros
	function automatic logic [VALUE_W-1:0] random_value();
		logic [63:0] mag;
		int pick;
		int sh;
		int tz;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			return 64'd0;
		if (pick < 7) begin
			case ($urandom_range(0, 3))
				0: return 64'h8000_0000_0000_0000;
				1: return 64'h7FFF_FFFF_FFFF_FFFF;
				2: return 64'hFFFF_FFFF_FFFF_FFFF;
				default: return 64'h0000_0000_0000_0001;
			endcase
		end
		if (pick < 17)
			return {$urandom, $urandom};
		sh = $urandom_range(0, 63);
		mag = ({$urandom, $urandom} | 64'h8000_0000_0000_0000) >> sh;
		if ($urandom_range(0, 2) == 0) begin
			tz = $urandom_range(0, 63);
			mag = mag & (~64'd0 << tz);
			if (mag == 64'd0)
				mag = 64'd1 << (63 - sh);
		end
		return $urandom_range(0, 1) ? (~mag + 64'd1) : mag;
	endfunction

	// wait until every word in flight has come back
	task automatic drain_pipeline();
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready
	task automatic write_register(logic [1:0] idx, logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_MANT_BITS: mant_bits_cfg = int'(data[5:0]);
			REG_MIN_EXP:   min_exp_cfg = int'($signed(data[7:0]));
			REG_MAX_EXP:   max_exp_cfg = int'($signed(data[7:0]));
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// program one register setting; upper data bits are random junk
	task automatic load_setting(cfg_set_t s);
		drain_pipeline();
		write_register(REG_MANT_BITS, {$urandom} << 6 | 32'(s.mant_bits));
		write_register(REG_MIN_EXP, {$urandom} << 8 | 32'(unsigned'(s.min_exp)));
		write_register(REG_MAX_EXP, {$urandom} << 8 | 32'(unsigned'(s.max_exp)));
	endtask

	// send one word, with burst gaps when enabled; queue its expected result
	task automatic issue_word(logic [VALUE_W-1:0] v, logic typed, norm_word_t want);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
				value <= {$urandom, $urandom};
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_words.push_back(typed ? want : normalize_value(v));
	endtask

	task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
			mismatch_count++;
		end
	endtask

	// result checker: every done word against the oldest expectation
	always @(posedge clk) begin
		norm_word_t want;
		norm_word_t got;
		if (arst_n && done === 1'b1) begin
			got = '{sign, exponent, mantissa, ones_complement, twos_complement,
				zero_flag, overflow_flag, underflow_flag, truncation_flag};
			if (pending_words.size() == 0) begin
				$display("%0t: result word with nothing expected, got %h", $time, got);
				mismatch_count++;
			end else begin
				want = pending_words.pop_front();
				if (got !== want) begin
					check_field("sign", 64'(want.sign), 64'(got.sign));
					check_field("exponent", 64'(unsigned'(want.exponent)),
						64'(unsigned'(got.exponent)));
					check_field("mantissa", 64'(want.mantissa), 64'(got.mantissa));
					check_field("ones_complement", 64'(want.ones_complement),
						64'(got.ones_complement));
					check_field("twos_complement", 64'(want.twos_complement),
						64'(got.twos_complement));
					check_field("zero_flag", 64'(want.zero_flag), 64'(got.zero_flag));
					check_field("overflow_flag", 64'(want.overflow_flag),
						64'(got.overflow_flag));
					check_field("underflow_flag", 64'(want.underflow_flag),
						64'(got.underflow_flag));
					check_field("truncation_flag", 64'(want.truncation_flag),
						64'(got.truncation_flag));
				end
			end
		end
	end

	// main sequence
	initial begin
		cfg_set_t s;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatch_count = 0;
		burst_left = 0;
		gaps_on = 1'b0;
		mant_bits_cfg = int'(MANT_BITS_RST);
		min_exp_cfg = int'($signed(MIN_EXP_RST));
		max_exp_cfg = int'($signed(MAX_EXP_RST));
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words at the reset setting, back to back
		foreach (dir_rows[i])
			issue_word(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
		@(negedge clk);
		start <= 1'b0;

		// random words under fixed and then random settings
		for (int p = 0; p < N_FIXED_SETS + N_RANDOM_SETS; p++) begin
			if (p < N_FIXED_SETS) begin
				s = fixed_sets[p];
			end else begin
				s.mant_bits = 6'($urandom_range(0, 63));
				if ($urandom_range(0, 3) == 0) begin
					s.min_exp = 8'($urandom);
					s.max_exp = 8'($urandom);
				end else begin
					s.min_exp = 8'($signed($urandom_range(0, 128)) - 64);
					s.max_exp = 8'($signed($urandom_range(0, 128)) - 64);
				end
			end
			load_setting(s);
			gaps_on = (p % 3) != 1;
			burst_left = 0;
			for (int k = 0; k < WORDS_PER_SET; k++)
				issue_word(random_value(), 1'b0, '0);
			@(negedge clk);
			start <= 1'b0;
		end

		drain_pipeline();
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
